FILE: hdl/sal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sal_pkg;

  // Diode count and the fixed field widths of the item
  localparam int DIODE_COUNT = 4;
  localparam int DIODE_BITS  = 2;
  localparam int INDEX_BITS  = 8;
  localparam int LEN_BITS    = 9;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 9'd256;
  localparam int LEN_MIN = 2;

  // Item kinds
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;

  // Diode pair that wraps around: diode 3 goes before diode 0
  localparam logic [DIODE_BITS-1:0] DIODE_WRAP_FIRST  = 2'd3;
  localparam logic [DIODE_BITS-1:0] DIODE_WRAP_SECOND = 2'd0;

  // Opposite diodes have indices that differ by two
  localparam logic [DIODE_BITS-1:0] OPPOSITE_XOR = 2'd2;

  // Status bit positions
  localparam int STAT_OPPOSITE = 0;
  localparam int STAT_OUTSIDE  = 1;

  // Lookup sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_CMP,
    S_PROBE,
    S_UPD,
    S_PICK,
    S_ANG,
    S_DONE
  } state_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic below;    // voltage under the low key
    logic above;    // voltage over the probed key
    logic key_le;   // probed key at or under the voltage
    logic pick_hi;  // high key strictly nearer than the low key
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: hdl/sal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/sal_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module sal_cmp
  import sal_pkg::*;
#(
  parameter int VOLT_BITS = 12
) (
  input  wire logic [VOLT_BITS-1:0] volt,
  input  wire logic [VOLT_BITS-1:0] key,
  input  wire logic [VOLT_BITS-1:0] key_lo,
  input  wire logic [VOLT_BITS-1:0] key_hi,
  output cmp_res_t                  res
);

  logic signed [VOLT_BITS+1:0] dist_lo;
  logic signed [VOLT_BITS+1:0] dist_hi;

  // Signed distances to both bracketing keys; ties go to the low entry
  always_comb begin
    dist_lo     = $signed({2'b00, volt}) - $signed({2'b00, key_lo});
    dist_hi     = $signed({2'b00, key_hi}) - $signed({2'b00, volt});
    res.below   = volt < key_lo;
    res.above   = key < volt;
    res.key_le  = key <= volt;
    res.pick_hi = dist_hi < dist_lo;
  end

endmodule

`default_nettype wire

FILE: hdl/sun_angle_lut_lookup_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Load word: written to the table RAM, no result word.
// Measure word: per diode, reads the first and last keys of the one-port table
// RAM, clamps when the voltage lies outside them, else probes by binary search,
// up to ceil(log2(len-1)) probes, and reads the nearer entry. One word at a time.
// Synchronous active-high reset clears the sequencer, output valid and sets
// every table length to 256; table RAM contents are not cleared.

module sun_angle_lut_lookup_core
  import sal_pkg::*;
#(
  parameter int TABLE_DEPTH = 256,
  parameter int VOLT_BITS   = 12,
  parameter int ANGLE_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [DIODE_BITS-1:0]        cfg_index,
  input  wire logic [LEN_BITS-1:0]          cfg_data,
  // input words
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         action,
  input  wire logic [DIODE_BITS-1:0]        diode_sel,
  input  wire logic [INDEX_BITS-1:0]        entry_index,
  input  wire logic [VOLT_BITS-1:0]         entry_voltage,
  input  wire logic signed [ANGLE_BITS-1:0] entry_angle_top,
  input  wire logic signed [ANGLE_BITS-1:0] entry_angle_bot,
  input  wire logic [VOLT_BITS-1:0]         sense_volt_0,
  input  wire logic [VOLT_BITS-1:0]         sense_volt_1,
  input  wire logic [VOLT_BITS-1:0]         sense_volt_2,
  input  wire logic [VOLT_BITS-1:0]         sense_volt_3,
  // result words
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [ANGLE_BITS-1:0]      sun_angle,
  output logic [DIODE_BITS-1:0]             first_diode,
  output logic [DIODE_BITS-1:0]             second_diode,
  output logic [1:0]                        status
);

  localparam int RAM_DEPTH = DIODE_COUNT * TABLE_DEPTH;
  localparam int AW        = $clog2(RAM_DEPTH);
  localparam int IW        = $clog2(TABLE_DEPTH);
  localparam int LW        = (IW + 1 > LEN_BITS) ? IW + 1 : LEN_BITS;
  localparam int RW        = VOLT_BITS + 2 * ANGLE_BITS;

  // Configuration registers
  logic [LEN_BITS-1:0] table_len [DIODE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIODE_COUNT; i++) begin
        table_len[i] <= LEN_RESET;
      end
    end else if (cfg_we) begin
      table_len[cfg_index] <= cfg_data;
    end
  end

  // Sequencer and datapath registers
  state_t                       state, state_next;
  logic                         cur, cur_next;
  logic [DIODE_BITS-1:0]        dfirst, dfirst_next;
  logic [DIODE_BITS-1:0]        dsecond, dsecond_next;
  logic [VOLT_BITS-1:0]         vfirst, vfirst_next;
  logic [VOLT_BITS-1:0]         vsecond, vsecond_next;
  logic                         opposite, opposite_next;
  logic                         outside, outside_next;
  logic [IW-1:0]                lo, lo_next;
  logic [IW-1:0]                hi, hi_next;
  logic [VOLT_BITS-1:0]         klo, klo_next;
  logic [VOLT_BITS-1:0]         khi, khi_next;
  logic signed [ANGLE_BITS-1:0] ang_bot, ang_bot_next;
  logic signed [ANGLE_BITS-1:0] ang_top, ang_top_next;
  logic                         out_valid_next;
  logic signed [ANGLE_BITS-1:0] sun_angle_next;
  logic [DIODE_BITS-1:0]        first_diode_next;
  logic [DIODE_BITS-1:0]        second_diode_next;
  logic [1:0]                   status_next;

  // Table RAM: {voltage, top angle, bottom angle}
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic [VOLT_BITS-1:0]         rd_key;
  logic signed [ANGLE_BITS-1:0] rd_top;
  logic signed [ANGLE_BITS-1:0] rd_bot;

  assign rd_key = ram_rdata[RW-1 -: VOLT_BITS];
  assign rd_top = $signed(ram_rdata[2*ANGLE_BITS-1 -: ANGLE_BITS]);
  assign rd_bot = $signed(ram_rdata[ANGLE_BITS-1:0]);

  // Write a table entry on an accepted load word inside the table
  assign ram_we    = in_valid && in_ready && (action == ACT_LOAD) &&
                     (32'(entry_index) < TABLE_DEPTH);
  assign ram_waddr = AW'(32'(diode_sel) * TABLE_DEPTH + 32'(entry_index));
  assign ram_wdata = {entry_voltage, entry_angle_top, entry_angle_bot};

  sal_ram #(
    .WIDTH (RW),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Diode under lookup and its effective last index
  logic [DIODE_BITS-1:0] cur_diode;
  logic [VOLT_BITS-1:0]  cur_volt;
  logic [LW-1:0]         len_ext;
  logic [IW-1:0]         last_idx;

  always_comb begin
    cur_diode = cur ? dsecond : dfirst;
    cur_volt  = cur ? vsecond : vfirst;
    len_ext   = LW'(table_len[cur_diode]);
    if (len_ext < LW'(LEN_MIN)) begin
      last_idx = IW'(LEN_MIN - 1);
    end else if (len_ext > LW'(TABLE_DEPTH)) begin
      last_idx = IW'(TABLE_DEPTH - 1);
    end else begin
      last_idx = IW'(len_ext - LW'(1));
    end
  end

  // Shared compare unit
  cmp_res_t cmp;

  sal_cmp #(
    .VOLT_BITS (VOLT_BITS)
  ) u_cmp (
    .volt   (cur_volt),
    .key    (rd_key),
    .key_lo (klo),
    .key_hi (khi),
    .res    (cmp)
  );

  // Brightest pair of the incoming measure word
  logic [VOLT_BITS-1:0]  volt_in [DIODE_COUNT];
  logic [DIODE_BITS-1:0] high, low, sel_first, sel_second;

  always_comb begin
    volt_in[0] = sense_volt_0;
    volt_in[1] = sense_volt_1;
    volt_in[2] = sense_volt_2;
    volt_in[3] = sense_volt_3;
    high = '0;
    for (int i = 1; i < DIODE_COUNT; i++) begin
      if (volt_in[i] > volt_in[high]) begin
        high = DIODE_BITS'(i);
      end
    end
    low = (high == '0) ? DIODE_BITS'(1) : '0;
    for (int i = 0; i < DIODE_COUNT; i++) begin
      if ((DIODE_BITS'(i) != high) && (volt_in[i] > volt_in[low])) begin
        low = DIODE_BITS'(i);
      end
    end
    if ((high == DIODE_WRAP_SECOND && low == DIODE_WRAP_FIRST) ||
        (high == DIODE_WRAP_FIRST && low == DIODE_WRAP_SECOND)) begin
      sel_first  = DIODE_WRAP_FIRST;
      sel_second = DIODE_WRAP_SECOND;
    end else if (high > low) begin
      sel_first  = low;
      sel_second = high;
    end else begin
      sel_first  = high;
      sel_second = low;
    end
  end

  // Search span, probe point and mean of the two angles
  logic [IW-1:0]              span, mid, upd_span;
  logic [IW-1:0]              rd_idx;
  logic signed [ANGLE_BITS:0] angle_sum;

  assign span      = hi - lo;
  assign mid       = lo + (span >> 1);
  assign angle_sum = {ang_bot[ANGLE_BITS-1], ang_bot} + {ang_top[ANGLE_BITS-1], ang_top};
  assign ram_raddr = AW'(32'(cur_diode) * TABLE_DEPTH + 32'(rd_idx));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cur       <= cur_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dfirst       <= dfirst_next;
    dsecond      <= dsecond_next;
    vfirst       <= vfirst_next;
    vsecond      <= vsecond_next;
    opposite     <= opposite_next;
    outside      <= outside_next;
    lo           <= lo_next;
    hi           <= hi_next;
    klo          <= klo_next;
    khi          <= khi_next;
    ang_bot      <= ang_bot_next;
    ang_top      <= ang_top_next;
    sun_angle    <= sun_angle_next;
    first_diode  <= first_diode_next;
    second_diode <= second_diode_next;
    status       <= status_next;
  end

  // Next state and outputs
  always_comb begin
    state_next        = state;
    cur_next          = cur;
    dfirst_next       = dfirst;
    dsecond_next      = dsecond;
    vfirst_next       = vfirst;
    vsecond_next      = vsecond;
    opposite_next     = opposite;
    outside_next      = outside;
    lo_next           = lo;
    hi_next           = hi;
    klo_next          = klo;
    khi_next          = khi;
    ang_bot_next      = ang_bot;
    ang_top_next      = ang_top;
    sun_angle_next    = sun_angle;
    first_diode_next  = first_diode;
    second_diode_next = second_diode;
    status_next       = status;
    out_valid_next    = out_valid && !out_ready;
    in_ready          = 1'b0;
    rd_idx            = lo;
    upd_span          = span;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        // Start a measure: latch the ordered pair and their voltages
        if (in_valid && action == ACT_MEASURE) begin
          dfirst_next   = sel_first;
          dsecond_next  = sel_second;
          vfirst_next   = volt_in[sel_first];
          vsecond_next  = volt_in[sel_second];
          opposite_next = (high ^ low) == OPPOSITE_XOR;
          outside_next  = 1'b0;
          cur_next      = 1'b0;
          state_next    = S_LO;
        end
      end

      S_LO: begin
        // Read the first key, set the search range
        rd_idx     = '0;
        lo_next    = '0;
        hi_next    = last_idx;
        state_next = S_HI;
      end

      S_HI: begin
        // Read the last key, hold the first
        rd_idx     = hi;
        klo_next   = rd_key;
        state_next = S_CMP;
      end

      S_CMP: begin
        // Clamp outside voltages, else start probing
        khi_next = rd_key;
        if (cmp.below) begin
          outside_next = 1'b1;
          rd_idx       = '0;
          state_next   = S_ANG;
        end else if (cmp.above) begin
          outside_next = 1'b1;
          rd_idx       = hi;
          state_next   = S_ANG;
        end else if (span > IW'(1)) begin
          state_next = S_PROBE;
        end else begin
          state_next = S_PICK;
        end
      end

      S_PROBE: begin
        rd_idx     = mid;
        state_next = S_UPD;
      end

      S_UPD: begin
        // Narrow the range around the probed key
        if (cmp.key_le) begin
          lo_next  = mid;
          klo_next = rd_key;
          upd_span = hi - mid;
        end else begin
          hi_next  = mid;
          khi_next = rd_key;
          upd_span = mid - lo;
        end
        state_next = (upd_span > IW'(1)) ? S_PROBE : S_PICK;
      end

      S_PICK: begin
        // Read the nearer bracketing entry
        rd_idx     = cmp.pick_hi ? hi : lo;
        state_next = S_ANG;
      end

      S_ANG: begin
        // Take the bottom angle of the first diode, top angle of the second
        if (!cur) begin
          ang_bot_next = rd_bot;
          cur_next     = 1'b1;
          state_next   = S_LO;
        end else begin
          ang_top_next = rd_top;
          state_next   = S_DONE;
        end
      end

      S_DONE: begin
        // Load the result word once the output register is free
        if (!out_valid || out_ready) begin
          sun_angle_next             = angle_sum[ANGLE_BITS:1];
          first_diode_next           = dfirst;
          second_diode_next          = dsecond;
          status_next[STAT_OPPOSITE] = opposite;
          status_next[STAT_OUTSIDE]  = outside;
          out_valid_next             = 1'b1;
          state_next                 = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/sal_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module sal_chk
  import sal_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         action,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [ANGLE_BITS-1:0] sun_angle,
  input wire logic [DIODE_BITS-1:0]        first_diode,
  input wire logic [DIODE_BITS-1:0]        second_diode,
  input wire logic [1:0]                   status
);

  // No result word right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid after reset");

  // A load word leaves the block ready for the next word
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_LOAD) |=> in_ready)
    else $error("block busy after load word");

  // A measure word keeps the block busy
  a_measure_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_MEASURE) |=> !in_ready)
    else $error("block ready right after measure word");

  // Two distinct diodes, opposite flag agrees with them
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (first_diode != second_diode) &&
      (status[STAT_OPPOSITE] == ((first_diode ^ second_diode) == OPPOSITE_XOR)))
    else $error("inconsistent diode pair in result word");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(sun_angle) &&
      $stable(first_diode) && $stable(second_diode) && $stable(status))
    else $error("stalled result word changed");

endmodule

bind sun_angle_lut_lookup_core sal_chk #(.ANGLE_BITS(ANGLE_BITS)) u_chk (.*);

`default_nettype wire
